### rtl/mtet_pkg.sv
// ----------------------------------------------------------------------------
// Marching tetrahedra package
// Shared types, tables and constants for the isosurface extractor.
// ----------------------------------------------------------------------------
package mtet_pkg;

  localparam int VW = 32;
  localparam int FW = 16;

  typedef struct packed {
    logic [1:0]          corner;
    logic signed [VW-1:0] coord_x;
    logic signed [VW-1:0] coord_y;
    logic signed [VW-1:0] coord_z;
    logic signed [VW-1:0] sample;
  } corner_t;

  typedef struct packed {
    logic signed [VW-1:0] a_x;
    logic signed [VW-1:0] a_y;
    logic signed [VW-1:0] a_z;
    logic signed [VW-1:0] b_x;
    logic signed [VW-1:0] b_y;
    logic signed [VW-1:0] b_z;
    logic signed [VW-1:0] c_x;
    logic signed [VW-1:0] c_y;
    logic signed [VW-1:0] c_z;
    logic [3:0]           case_code;
    logic                 final_triangle;
  } tri_t;

  // One snapshot of a classified tetrahedron, handed from front to back.
  typedef struct packed {
    logic signed [3:0][VW-1:0] cx;
    logic signed [3:0][VW-1:0] cy;
    logic signed [3:0][VW-1:0] cz;
    logic signed [3:0][VW-1:0] s;
    logic signed [VW-1:0]      iso;
    logic [3:0]                code;
  } tetra_t;

  function automatic logic [1:0] tri_count(input logic [3:0] code);
    case (code)
      4'd0, 4'd15: tri_count = 2'd0;
      4'd3, 4'd5, 4'd6, 4'd9, 4'd10, 4'd12: tri_count = 2'd2;
      default: tri_count = 2'd1;
    endcase
  endfunction

  // Edge for triangle k (0..1), vertex v (0..2).
  function automatic logic [2:0] tri_edge(input logic [3:0] code, input logic k,
                                          input logic [1:0] v);
    logic [17:0] row;
    case (code)
      4'd1:  row = {3'd0, 3'd3, 3'd2, 3'd0, 3'd0, 3'd0};
      4'd2:  row = {3'd0, 3'd1, 3'd4, 3'd0, 3'd0, 3'd0};
      4'd3:  row = {3'd3, 3'd2, 3'd4, 3'd4, 3'd2, 3'd1};
      4'd4:  row = {3'd1, 3'd2, 3'd5, 3'd0, 3'd0, 3'd0};
      4'd5:  row = {3'd3, 3'd5, 3'd1, 3'd3, 3'd1, 3'd0};
      4'd6:  row = {3'd0, 3'd2, 3'd5, 3'd0, 3'd5, 3'd4};
      4'd7:  row = {3'd3, 3'd5, 3'd4, 3'd0, 3'd0, 3'd0};
      4'd8:  row = {3'd3, 3'd4, 3'd5, 3'd0, 3'd0, 3'd0};
      4'd9:  row = {3'd0, 3'd4, 3'd5, 3'd0, 3'd5, 3'd2};
      4'd10: row = {3'd0, 3'd5, 3'd3, 3'd0, 3'd1, 3'd5};
      4'd11: row = {3'd5, 3'd2, 3'd1, 3'd0, 3'd0, 3'd0};
      4'd12: row = {3'd3, 3'd4, 3'd1, 3'd3, 3'd1, 3'd2};
      4'd13: row = {3'd0, 3'd4, 3'd1, 3'd0, 3'd0, 3'd0};
      4'd14: row = {3'd0, 3'd2, 3'd3, 3'd0, 3'd0, 3'd0};
      default: row = '0;
    endcase
    tri_edge = row[17 - 3*(3*k + v) -: 3];
  endfunction

  function automatic logic [1:0] edge_p(input logic [2:0] e);
    case (e)
      3'd0: edge_p = 2'd0;
      3'd1: edge_p = 2'd1;
      3'd2: edge_p = 2'd2;
      3'd3: edge_p = 2'd0;
      3'd4: edge_p = 2'd1;
      default: edge_p = 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] edge_q(input logic [2:0] e);
    case (e)
      3'd0: edge_q = 2'd1;
      3'd1: edge_q = 2'd2;
      3'd2: edge_q = 2'd0;
      default: edge_q = 2'd3;
    endcase
  endfunction

endpackage

### rtl/mtet_if.sv
// ----------------------------------------------------------------------------
// Valid/ready channel
// Generic handshake interface carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface mtet_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/mtet_front.sv
// ----------------------------------------------------------------------------
// Front end
// Stores corners, holds the threshold and classifies each tetrahedron.
// ----------------------------------------------------------------------------
module mtet_front (
  input  logic                   clk,
  input  logic                   rst,
  input  mtet_pkg::corner_t      in_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [mtet_pkg::VW-1:0] cfg_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  output mtet_pkg::tetra_t       q_data,
  output logic                   q_valid,
  input  logic                   q_ready
);
  import mtet_pkg::*;

  logic signed [3:0][VW-1:0] cx, cy, cz, s;
  logic signed [VW-1:0] iso;
  tetra_t snap;
  logic [3:0] code;
  logic take;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_valid || q_ready;
  assign take      = in_valid && in_ready;

  always_comb begin
    snap    = '0;
    snap.cx = cx;
    snap.cy = cy;
    snap.cz = cz;
    snap.s  = s;
    snap.cx[3] = in_data.coord_x;
    snap.cy[3] = in_data.coord_y;
    snap.cz[3] = in_data.coord_z;
    snap.s[3]  = in_data.sample;
    snap.iso   = iso;
    for (int i = 0; i < 4; i++) begin
      code[i] = ($signed(snap.s[i]) >= iso);
    end
    snap.code = code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iso     <= '0;
      q_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        iso <= cfg_data;
      end
      q_valid <= (q_valid && !q_ready) ||
                 (take && in_data.corner == 2'd3 && tri_count(code) != 2'd0);
    end
    if (take) begin
      cx[in_data.corner] <= in_data.coord_x;
      cy[in_data.corner] <= in_data.coord_y;
      cz[in_data.corner] <= in_data.coord_z;
      s[in_data.corner]  <= in_data.sample;
    end
    if (take && in_data.corner == 2'd3 && in_ready) begin
      q_data <= snap;
    end
  end
endmodule

### rtl/mtet_back.sv
// ----------------------------------------------------------------------------
// Back end
// Interpolates triangle vertices with a serial divider and emits triangles.
// ----------------------------------------------------------------------------
module mtet_back (
  input  logic             clk,
  input  logic             rst,
  input  mtet_pkg::tetra_t q_data,
  input  logic             q_valid,
  output logic             q_ready,
  output mtet_pkg::tri_t   out_data,
  output logic             out_valid,
  input  logic             out_ready
);
  import mtet_pkg::*;

  typedef enum logic [2:0] {IDLE, SETUP, DIVIDE, MUL, ACC, EMIT} state_t;

  state_t state;
  tetra_t job;
  logic       tri_k;
  logic [1:0] vtx;
  logic [1:0] axis;
  logic [1:0] st, en;
  logic [VW:0] num, den, rem;
  logic [FW:0] t;
  logic [4:0] step;
  logic signed [VW-1:0] base, far;
  logic [VW:0] mag;
  logic [VW+FW:0] prod;
  logic signed [VW-1:0] pt [9];
  logic [2:0] e;
  logic [1:0] p, q;
  logic signed [VW:0] d, n, diff;
  logic [VW:0] rem2;

  assign q_ready = (state == IDLE);
  assign e = tri_edge(job.code, tri_k, vtx);
  assign p = edge_p(e);
  assign q = edge_q(e);
  assign d = $signed({job.s[q][VW-1], job.s[q]}) - $signed({job.s[p][VW-1], job.s[p]});
  assign rem2 = {rem[VW-1:0], 1'b0};

  always_comb begin
    case (axis)
      2'd0: begin base = job.cx[st]; far = job.cx[en]; end
      2'd1: begin base = job.cy[st]; far = job.cy[en]; end
      default: begin base = job.cz[st]; far = job.cz[en]; end
    endcase
    diff = $signed({far[VW-1], far}) - $signed({base[VW-1], base});
    n = $signed({job.iso[VW-1], job.iso}) - $signed({job.s[st][VW-1], job.s[st]});
    prod = (mag[VW:FW] * t << FW) + (mag[FW-1:0] * t);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= (out_valid && !out_ready) || (state == EMIT);
      case (state)
        IDLE: begin
          if (q_valid) begin
            job   <= q_data;
            tri_k <= 1'b0;
            vtx   <= 2'd0;
            state <= SETUP;
          end
        end
        SETUP: begin
          if (d > 0) begin
            st <= p; en <= q; den <= d;
          end else begin
            st <= q; en <= p; den <= -d;
          end
          state <= DIVIDE;
          step  <= '0;
          axis  <= 2'd0;
          t     <= '0;
          num   <= '0;
        end
        DIVIDE: begin
          if (step == 5'd0) begin
            if (den == '0 || n <= 0) begin
              t <= '0; state <= MUL;
            end else if (n >= $signed(den)) begin
              t <= {1'b1, {FW{1'b0}}}; state <= MUL;
            end else begin
              rem <= n; step <= 5'd1;
            end
          end else begin
            if (rem2 >= den) begin
              rem <= rem2 - den; t <= {t[FW-1:0], 1'b1};
            end else begin
              rem <= rem2; t <= {t[FW-1:0], 1'b0};
            end
            if (step == 5'(FW)) begin
              state <= MUL;
            end
            step <= step + 5'd1;
          end
        end
        MUL: begin
          mag  <= diff[VW] ? -diff : diff;
          num  <= diff;
          state <= ACC;
        end
        ACC: begin
          pt[4'(vtx) * 4'd3 + 4'(axis)] <= num[VW] ? base - VW'(prod >> FW)
                                                   : base + VW'(prod >> FW);
          if (axis == 2'd2) begin
            if (vtx == 2'd2) begin
              state <= EMIT;
            end else begin
              vtx <= vtx + 2'd1; state <= SETUP;
            end
          end else begin
            axis <= axis + 2'd1; state <= MUL;
          end
        end
        EMIT: begin
          if (!out_valid || out_ready) begin
            out_data.a_x <= pt[0]; out_data.a_y <= pt[1]; out_data.a_z <= pt[2];
            out_data.b_x <= pt[3]; out_data.b_y <= pt[4]; out_data.b_z <= pt[5];
            out_data.c_x <= pt[6]; out_data.c_y <= pt[7]; out_data.c_z <= pt[8];
            out_data.case_code <= job.code;
            out_data.final_triangle <= (tri_count(job.code) == 2'd1) || tri_k;
            if (tri_count(job.code) == 2'd2 && !tri_k) begin
              tri_k <= 1'b1; vtx <= 2'd0; state <= SETUP;
            end else begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

### rtl/marching_tetra_isosurface.sv
// ----------------------------------------------------------------------------
// Marching tetrahedra isosurface extractor
// Takes tetrahedron corners and emits interpolated isosurface triangles.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload
// in       sink       corner, coord_x/y/z, sample
// out      source     a/b/c vertices, case_code, final_triangle
// cfg      sink       iso_value
// A corner is stored when it is taken. A corner 3 that yields triangles goes into a
// one-entry queue, and every input transaction waits while that queue is full
// and the back end is busy. A vertex runs the 16-step divider only when its
// edge fraction is neither 0 nor 1, and a triangle's output can be held by
// output stalls. Reset clears control state and the threshold.
module marching_tetra_isosurface (
  input logic clk,
  input logic rst,
  mtet_if.sink   in,
  mtet_if.source out,
  mtet_if.sink   cfg
);
  import mtet_pkg::*;

  tetra_t q_data;
  logic q_valid, q_ready;

  mtet_front u_front (
    .clk, .rst,
    .in_data(in.data), .in_valid(in.valid), .in_ready(in.ready),
    .cfg_data(cfg.data), .cfg_valid(cfg.valid), .cfg_ready(cfg.ready),
    .q_data, .q_valid, .q_ready
  );

  mtet_back u_back (
    .clk, .rst,
    .q_data, .q_valid, .q_ready,
    .out_data(out.data), .out_valid(out.valid), .out_ready(out.ready)
  );
endmodule
